### src/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, widths and the month table for the DOS timestamp converter.
// ----------------------------------------------------------------------------
package dts_pkg;

   localparam int DATE_W    = 16;
   localparam int TIME_W    = 16;
   localparam int YEARS_W   = 7;
   localparam int MONTH_W   = 4;
   localparam int DOM_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SEC_W     = 6;
   localparam int DAY_W     = 16;
   localparam int HOURS_W   = 21;
   localparam int MINUTES_W = 27;
   localparam int SECONDS_W = 33;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // One decoded item between the front and the back.
   typedef struct packed {
      logic [DAY_W-1:0]    days;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SEC_W-1:0]    second;
      logic                month_invalid;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic can_push;
      logic nonempty;
   } queue_status_type;

   // Days in the months before month m (January is month 1).
   function automatic logic [DAY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      d = '0;
      unique case (m)
         4'd0, 4'd1: d = 16'd0;
         4'd2:       d = 16'd31;
         4'd3:       d = 16'd59;
         4'd4:       d = 16'd90;
         4'd5:       d = 16'd120;
         4'd6:       d = 16'd151;
         4'd7:       d = 16'd181;
         4'd8:       d = 16'd212;
         4'd9:       d = 16'd243;
         4'd10:      d = 16'd273;
         4'd11:      d = 16'd304;
         default:    d = 16'd334;
      endcase
      return d;
   endfunction

endpackage

### src/dos_timestamp_to_unix_seconds_unit.sv
// ----------------------------------------------------------------------------
// dos_timestamp_to_unix_seconds_unit
// Converts a packed DOS date and time to seconds since 1970.
// ----------------------------------------------------------------------------
// A new transaction can be started in every cycle while busy is low; busy stays
// low in normal use, since the back end drains its queue each cycle and the
// receiver never stalls. The result appears on the rsp_ ports for one cycle,
// marked by rsp_valid, after start is taken and the item has passed the front
// register that works out the day count, the queue, and the back-end stages
// where one multiply-add per stage folds in hours, minutes and seconds.
// Every fourth year is taken as a leap year; a month of 0 or above 12 raises
// rsp_month_invalid and the month sum stops at December.
module dos_timestamp_to_unix_seconds_unit
   import dts_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATE_W-1:0]     req_dos_date,
   input  logic [TIME_W-1:0]     req_dos_time,
   output logic                  rsp_valid,
   output logic [SECONDS_W-1:0]  rsp_unix_seconds,
   output logic                  rsp_month_invalid
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        pop_entry;

   dts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_dos_date (req_dos_date),
      .req_dos_time (req_dos_time),
      .q_status     (q_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   dts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   dts_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_unix_seconds  (rsp_unix_seconds),
      .rsp_month_invalid (rsp_month_invalid)
   );

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("transaction result missing after five cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without a matching transaction");
`endif

endmodule

### src/dts_front.sv
// ----------------------------------------------------------------------------
// dts_front
// Accepts a DOS date and time, unpacks the fields and works out the day count.
// ----------------------------------------------------------------------------
module dts_front
   import dts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATE_W-1:0]     req_dos_date,
   input  logic [TIME_W-1:0]     req_dos_time,
   input  queue_status_type      q_status,
   output logic                  push,
   output entry_type             push_entry
);

   logic                 valid_ff, valid_in;
   entry_type            entry_ff, entry_in;
   logic                 accept;

   logic [YEARS_W-1:0]   years;
   logic [MONTH_W-1:0]   month;
   logic [DOM_W-1:0]     dom;
   logic [MONTH_W-1:0]   last_month;
   logic [DAY_W-1:0]     year_days;
   logic [DAY_W-1:0]     leap_days;
   logic [DAY_W-1:0]     leap_this;
   logic                 invalid;

   assign push       = valid_ff && q_status.can_push;
   assign push_entry = entry_ff;
   assign busy       = valid_ff && !q_status.can_push;
   assign accept     = start && !busy;

   always_comb begin
      years      = req_dos_date[15:9];
      month      = req_dos_date[8:5];
      dom        = req_dos_date[4:0];
      invalid    = (month == '0) || (month > MONTH_DEC);
      last_month = (month > MONTH_DEC) ? MONTH_DEC : month;

      year_days  = (DAY_W'(years) + DAY_W'(10)) * DAY_W'(365) + DAY_W'(2);
      leap_days  = DAY_W'((8'(years) + 8'd3) >> 2);
      leap_this  = ((years[1:0] == 2'b00) && (month > MONTH_FEB)) ? DAY_W'(1) : '0;

      entry_in.days          = year_days + leap_days + days_before_month(last_month)
                               + leap_this + DAY_W'(dom) - DAY_W'(1);
      entry_in.hour          = req_dos_time[15:11];
      entry_in.minute        = req_dos_time[10:5];
      entry_in.second        = {req_dos_time[4:0], 1'b0};
      entry_in.month_invalid = invalid;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### src/dts_queue.sv
// ----------------------------------------------------------------------------
// dts_queue
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dts_queue
   import dts_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               full;

   assign full              = (count_ff == CNT_W'(DEPTH));
   assign q_status.nonempty = (count_ff != '0);
   assign q_status.can_push = !full || pop;
   assign pop_entry         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("queue pushed while full");
`endif

endmodule

### src/dts_back.sv
// ----------------------------------------------------------------------------
// dts_back
// Folds hours, minutes and seconds into the day count over three stages.
// ----------------------------------------------------------------------------
module dts_back
   import dts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  entry_type             pop_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [SECONDS_W-1:0]  rsp_unix_seconds,
   output logic                  rsp_month_invalid
);

   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [HOURS_W-1:0]    s1_hours_ff, s1_hours_in;
   logic [MINUTE_W-1:0]   s1_minute_ff;
   logic [SEC_W-1:0]      s1_second_ff, s2_second_ff;
   logic                  s1_inv_ff, s2_inv_ff, s3_inv_ff;
   logic [MINUTES_W-1:0]  s2_minutes_ff, s2_minutes_in;
   logic [SECONDS_W-1:0]  s3_seconds_ff, s3_seconds_in;

   // Drain the queue every cycle: the receiver never stalls.
   assign pop = q_status.nonempty;

   assign s1_hours_in   = HOURS_W'(pop_entry.days) * HOURS_W'(24)
                          + HOURS_W'(pop_entry.hour);
   assign s2_minutes_in = MINUTES_W'(s1_hours_ff) * MINUTES_W'(60)
                          + MINUTES_W'(s1_minute_ff);
   assign s3_seconds_in = SECONDS_W'(s2_minutes_ff) * SECONDS_W'(60)
                          + SECONDS_W'(s2_second_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hours_ff   <= s1_hours_in;
      s1_minute_ff  <= pop_entry.minute;
      s1_second_ff  <= pop_entry.second;
      s1_inv_ff     <= pop_entry.month_invalid;
      s2_minutes_ff <= s2_minutes_in;
      s2_second_ff  <= s1_second_ff;
      s2_inv_ff     <= s1_inv_ff;
      s3_seconds_ff <= s3_seconds_in;
      s3_inv_ff     <= s2_inv_ff;
   end

   assign rsp_valid         = s3_valid_ff;
   assign rsp_unix_seconds  = s3_seconds_ff;
   assign rsp_month_invalid = s3_inv_ff;

endmodule
